/* rtl/ssp_pkg.sv */
// Package for the servo slew pulse generator.
// Holds item codes, register indexes, divide constants and the stage struct.
// No dependencies.
package ssp_pkg;

    localparam int ANGLE_W = 17;
    localparam int STEP_W  = 11;
    localparam int PULSE_W = 16;
    localparam int SLOPE_W = 24;
    localparam int MAXA_W  = 16;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;

    // speed * tick period, saturated so that the quotient tops out at 2047
    localparam int RATE_W    = 21;
    localparam int STEP_SAT  = 2048000;
    // floor(x / 1000) == (x * DIV_MULT) >> DIV_SHIFT for every x below 2^21
    localparam int DIV_SHIFT = 31;
    localparam int DIV_MULT  = 2147484;
    localparam int DIV_M_W   = 22;
    localparam int DIV_P_W   = RATE_W + DIV_M_W;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SET    = 2'd1,
        MODE_SMOOTH = 2'd2
    } ssp_mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_PULSE   = 2'd0,
        REG_PULSE_SLOPE = 2'd1,
        REG_MAX_ANGLE   = 2'd2
    } ssp_reg_idx_t;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 16'd500;
    localparam logic [SLOPE_W-1:0] PULSE_SLOPE_RST = 24'd7282;
    localparam logic [MAXA_W-1:0]  MAX_ANGLE_RST   = 16'd18000;

    typedef struct packed {
        logic                      valid;
        logic signed [ANGLE_W-1:0] angle;
        logic                      moving;
    } ssp_snap_t;

endpackage

/* rtl/ssp_ramp.sv */
// Input register, ramp state and per-item snapshot stage.
// Depends on ssp_pkg.
module ssp_ramp import ssp_pkg::*; #(
    parameter int TICK_PERIOD_MS = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic signed [ANGLE_W-1:0] s_target_angle,
    input  logic [15:0]               s_speed,
    output ssp_snap_t                 snap,
    input  logic                      snap_ready
);

    logic                      s1_valid_reg;
    logic [1:0]                s1_mode_reg;
    logic signed [ANGLE_W-1:0] s1_target_reg;
    logic [RATE_W-1:0]         s1_rate_reg;
    logic [RATE_W-1:0]         s1_rate_next;
    logic [31:0]               speed_prod;

    logic signed [ANGLE_W-1:0] present_reg;
    logic signed [ANGLE_W-1:0] present_next;
    logic signed [ANGLE_W-1:0] goal_reg;
    logic signed [ANGLE_W-1:0] goal_next;
    logic [STEP_W-1:0]         step_reg;
    logic [STEP_W-1:0]         step_next;
    logic                      active_reg;
    logic                      active_next;

    logic                      s2_valid_reg;
    logic signed [ANGLE_W-1:0] s2_angle_reg;
    logic                      s2_moving_reg;

    logic                      s2_load;
    logic [DIV_P_W-1:0]        quot_prod;
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]          mag;

    assign s2_load = !s2_valid_reg || snap_ready;
    assign s_ready = !s1_valid_reg || s2_load;

    assign speed_prod   = 32'(s_speed) * 32'(TICK_PERIOD_MS);
    assign s1_rate_next = (speed_prod >= 32'(STEP_SAT)) ? RATE_W'(STEP_SAT - 1)
                                                        : speed_prod[RATE_W-1:0];

    assign quot_prod = DIV_P_W'(s1_rate_reg) * DIV_P_W'(DIV_MULT);
    assign diff      = (ANGLE_W+1)'(goal_reg) - (ANGLE_W+1)'(present_reg);
    assign mag       = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : (ANGLE_W+1)'(diff);

    always_comb begin
        present_next = present_reg;
        goal_next    = goal_reg;
        step_next    = step_reg;
        active_next  = active_reg;
        case (s1_mode_reg)
            MODE_SET: begin
                active_next  = 1'b0;
                present_next = s1_target_reg;
                goal_next    = s1_target_reg;
            end
            MODE_SMOOTH: begin
                goal_next   = s1_target_reg;
                step_next   = quot_prod[DIV_SHIFT +: STEP_W];
                active_next = 1'b1;
            end
            MODE_TICK: begin
                if (active_reg) begin
                    if (mag <= (ANGLE_W+1)'(step_reg)) begin
                        present_next = goal_reg;
                        active_next  = 1'b0;
                    end else if (diff[ANGLE_W]) begin
                        present_next = present_reg - ANGLE_W'(step_reg);
                    end else begin
                        present_next = present_reg + ANGLE_W'(step_reg);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            present_reg  <= '0;
            goal_reg     <= '0;
            step_reg     <= '0;
            active_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_load) begin
                s2_valid_reg <= s1_valid_reg;
                if (s1_valid_reg) begin
                    present_reg <= present_next;
                    goal_reg    <= goal_next;
                    step_reg    <= step_next;
                    active_reg  <= active_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_mode_reg   <= s_mode;
            s1_target_reg <= s_target_angle;
            s1_rate_reg   <= s1_rate_next;
        end
        if (s2_load && s1_valid_reg) begin
            s2_angle_reg  <= present_next;
            s2_moving_reg <= active_next;
        end
    end

    assign snap.valid  = s2_valid_reg;
    assign snap.angle  = s2_angle_reg;
    assign snap.moving = s2_moving_reg;

endmodule

/* rtl/ssp_pulse_map.sv */
// Angle clamp, Q16 slope multiply and saturating pulse add into the result register.
// Depends on ssp_pkg.
module ssp_pulse_map import ssp_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ssp_snap_t                 snap,
    output logic                      snap_ready,
    input  logic [PULSE_W-1:0]        min_pulse,
    input  logic [SLOPE_W-1:0]        pulse_slope,
    input  logic [MAXA_W-1:0]         max_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [PULSE_W-1:0]        m_pulse_width,
    output logic signed [ANGLE_W-1:0] m_current_angle,
    output logic                      m_moving
);

    logic                      m_valid_reg;
    logic [PULSE_W-1:0]        pulse_reg;
    logic [PULSE_W-1:0]        pulse_next;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      moving_reg;

    logic [MAXA_W-1:0]           clamped;
    logic [MAXA_W+SLOPE_W-1:0]   scaled;
    logic [SLOPE_W:0]            sum;

    assign snap_ready = !m_valid_reg || m_ready;

    always_comb begin
        if (snap.angle[ANGLE_W-1]) begin
            clamped = '0;
        end else if (snap.angle > $signed({1'b0, max_angle})) begin
            clamped = max_angle;
        end else begin
            clamped = snap.angle[MAXA_W-1:0];
        end
    end

    assign scaled     = (MAXA_W+SLOPE_W)'(clamped) * (MAXA_W+SLOPE_W)'(pulse_slope);
    assign sum        = (SLOPE_W+1)'(min_pulse) + (SLOPE_W+1)'(scaled[16 +: SLOPE_W]);
    assign pulse_next = (sum > (SLOPE_W+1)'({PULSE_W{1'b1}})) ? {PULSE_W{1'b1}}
                                                             : sum[PULSE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            m_valid_reg <= snap.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap.valid) begin
            pulse_reg  <= pulse_next;
            angle_reg  <= snap.angle;
            moving_reg <= snap.moving;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pulse_width   = pulse_reg;
    assign m_current_angle = angle_reg;
    assign m_moving        = moving_reg;

endmodule

/* rtl/servo_slew_pulse_generator_unit.sv */
// Top level of the servo slew pulse generator: configuration registers and stages.
// Depends on ssp_pkg, ssp_ramp and ssp_pulse_map.
//
//   port group | direction | transfer when
//   s_*        | in        | s_valid && s_ready
//   m_*        | out       | m_valid && m_ready
//   cfg_*      | in        | cfg_we
//
// One item per cycle sustained while m_ready stays high; each result passes through
// the input register, the ramp state register and the result register.
// The ramp state update is the only loop and feeds back through the ramp state registers.
// Reset clears the ramp state and loads the register defaults.
// A stalled result holds its register; earlier stages keep filling until all are full.
module servo_slew_pulse_generator_unit import ssp_pkg::*; #(
    parameter int TICK_PERIOD_MS = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic signed [ANGLE_W-1:0] s_target_angle,
    input  logic [15:0]               s_speed,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [PULSE_W-1:0]        m_pulse_width,
    output logic signed [ANGLE_W-1:0] m_current_angle,
    output logic                      m_moving,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata
);

    logic [PULSE_W-1:0] min_pulse_reg;
    logic [SLOPE_W-1:0] pulse_slope_reg;
    logic [MAXA_W-1:0]  max_angle_reg;
    ssp_snap_t          snap;
    logic               snap_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg   <= MIN_PULSE_RST;
            pulse_slope_reg <= PULSE_SLOPE_RST;
            max_angle_reg   <= MAX_ANGLE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_PULSE:   min_pulse_reg   <= cfg_wdata[PULSE_W-1:0];
                REG_PULSE_SLOPE: pulse_slope_reg <= cfg_wdata[SLOPE_W-1:0];
                REG_MAX_ANGLE:   max_angle_reg   <= cfg_wdata[MAXA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssp_ramp #(
        .TICK_PERIOD_MS (TICK_PERIOD_MS)
    ) u_ramp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_target_angle (s_target_angle),
        .s_speed        (s_speed),
        .snap           (snap),
        .snap_ready     (snap_ready)
    );

    ssp_pulse_map u_map (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .snap            (snap),
        .snap_ready      (snap_ready),
        .min_pulse       (min_pulse_reg),
        .pulse_slope     (pulse_slope_reg),
        .max_angle       (max_angle_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pulse_width   (m_pulse_width),
        .m_current_angle (m_current_angle),
        .m_moving        (m_moving)
    );

endmodule

/* rtl/ssp_checker.sv */
// Port-level checks for the servo slew pulse generator, bound to the top level.
// Depends on ssp_pkg and servo_slew_pulse_generator_unit.
module ssp_checker import ssp_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [PULSE_W-1:0]        m_pulse_width,
    input logic signed [ANGLE_W-1:0] m_current_angle,
    input logic                      m_moving
);

    logic [2:0] pending_reg;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (s_xfer && !m_xfer) begin
            pending_reg <= pending_reg + 3'd1;
        end else if (m_xfer && !s_xfer) begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result without a pending item");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd3)
        else $error("more items in flight than stages");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg == 3'd3 && !m_ready) |-> !s_ready)
        else $error("input taken with all stages full");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pulse_width)
            && $stable(m_current_angle) && $stable(m_moving)))
        else $error("stalled result changed");

endmodule

bind servo_slew_pulse_generator_unit ssp_checker u_ssp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pulse_width   (m_pulse_width),
    .m_current_angle (m_current_angle),
    .m_moving        (m_moving)
);
